// ----- rtl/core/grfd_pkg.sv -----
// Shared types and constants for the glucose record frame decoder.
// No dependencies; every other file in rtl/core imports this package.
package grfd_pkg;

  localparam int unsigned CountSat   = 22;
  localparam int unsigned SummaryLen = 11;
  localparam int unsigned RecordLen  = 21;
  localparam int unsigned NumKept    = 9;

  localparam logic [7:0] HeaderReset = 8'h4F;
  localparam logic [7:0] ReturnReset = 8'h9E;

  typedef enum logic [0:0] {
    REG_HEADER_BYTE      = 1'b0,
    REG_RECORD_RETURN_ID = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_REJECTED = 2'd0,
    STATUS_SUMMARY  = 2'd1,
    STATUS_RECORD   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MEAL_BEFORE  = 2'd0,
    MEAL_AFTER   = 2'd1,
    MEAL_GENERAL = 2'd2
  } meal_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } frame_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] record_total;
    logic [15:0] record_capacity;
    logic [15:0] last_sent_index;
    logic [9:0]  glucose_value;
    logic [26:0] measured_key;
    logic [1:0]  meal_mode;
  } frame_out_t;

  // Per-frame state handed from the accumulator to the decoder.
  typedef struct packed {
    logic [4:0]                byte_count;
    logic [7:0]                running_sum;
    logic                      header_matched;
    logic [NumKept-1:0][7:0]   frame_bytes;   // index 0 holds frame byte 1
  } frame_state_t;

endpackage

// ----- rtl/core/glucose_record_frame_decoder.sv -----
// Top level of the glucose meter response frame decoder.
// Depends on grfd_pkg, grfd_frame_accum and grfd_result_decode.
//
//  port group  | dir | handshake          | moves
//  ------------+-----+--------------------+---------------------------------
//  in_*        | in  | in_valid/in_ready  | one frame byte + last-byte mark
//  out_*       | out | out_valid/out_ready| one decoded result per frame
//  cfg_*       | in  | cfg_wr_en          | header_byte / record_return_id
//
// One transaction per cycle on the input. A non-marked byte only updates the
// frame state and yields nothing. A marked byte is decoded in the same cycle
// it is taken and its result lands in the output register the next cycle,
// so throughput is one byte per clock unless a marked byte stalls.
// Reset (synchronous, rst high) clears the frame count, sum, header flag and
// output valid and loads the register defaults 0x4F and 0x9E.
// Stalls: only a marked byte waits, and only while the output register
// holds a result not yet taken and out_ready is low; plain bytes always flow.
module glucose_record_frame_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  grfd_pkg::frame_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output grfd_pkg::frame_out_t out_data,
  input  logic                 cfg_wr_en,
  input  logic [0:0]           cfg_index,
  input  logic [7:0]           cfg_data
);
  import grfd_pkg::*;

  logic [7:0]   header_reg;
  logic [7:0]   record_return_id;
  logic         take;
  logic         out_free;
  frame_state_t state;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      header_reg       <= HeaderReset;
      record_return_id <= ReturnReset;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HEADER_BYTE:      header_reg       <= cfg_data;
        REG_RECORD_RETURN_ID: record_return_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output slot is free if empty or being drained this cycle.
  assign out_free    = !out_valid || out_ready;
  assign in_ready    = out_free || !in_data.last_byte;
  assign take        = in_valid && in_ready;

  grfd_frame_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .item        (in_data),
    .header_byte (header_reg),
    .state       (state)
  );

  grfd_result_decode u_decode (
    .clk              (clk),
    .rst              (rst),
    .load             (take && in_data.last_byte),
    .check_byte       (in_data.byte_value),
    .state            (state),
    .record_return_id (record_return_id),
    .pop              (out_ready),
    .res_valid        (out_valid),
    .result           (out_data)
  );

endmodule

// ----- rtl/core/grfd_frame_accum.sv -----
// Frame accumulator: byte count, running sum, header check, bytes 1..9.
// Depends on grfd_pkg.
module grfd_frame_accum (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  grfd_pkg::frame_in_t    item,
  input  logic [7:0]             header_byte,
  output grfd_pkg::frame_state_t state
);
  import grfd_pkg::*;

  logic [4:0]              byte_count;
  logic [7:0]              running_sum;
  logic                    header_matched;
  logic [NumKept-1:0][7:0] frame_bytes;

  // Control state: cleared on reset and after every marked byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      running_sum    <= '0;
      header_matched <= 1'b0;
    end else if (take) begin
      if (item.last_byte) begin
        byte_count     <= '0;
        running_sum    <= '0;
        header_matched <= 1'b0;
      end else begin
        if (byte_count == '0) begin
          header_matched <= (item.byte_value == header_byte);
        end
        running_sum <= running_sum + item.byte_value;
        if (byte_count < 5'(CountSat)) begin
          byte_count <= byte_count + 5'd1;
        end
      end
    end
  end

  // Kept bytes: payload only, no reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NumKept; i++) begin
      if (take && !item.last_byte && byte_count == 5'(i + 1)) begin
        frame_bytes[i] <= item.byte_value;
      end
    end
  end

  assign state.byte_count     = byte_count;
  assign state.running_sum    = running_sum;
  assign state.header_matched = header_matched;
  assign state.frame_bytes    = frame_bytes;

endmodule

// ----- rtl/core/grfd_result_decode.sv -----
// Frame decoder on the checksum byte, with the result register.
// Depends on grfd_pkg.
module grfd_result_decode (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,       // marked byte taken this cycle
  input  logic [7:0]             check_byte,
  input  grfd_pkg::frame_state_t state,
  input  logic [7:0]             record_return_id,
  input  logic                   pop,        // result taken downstream
  output logic                   res_valid,
  output grfd_pkg::frame_out_t   result
);
  import grfd_pkg::*;

  frame_out_t res_next;
  logic       frame_ok;
  logic       is_summary;
  logic       is_record;
  logic [7:0] d0, d1, d2, d3, d4, d5;
  logic [4:0] month;
  logic [5:0] day;
  logic [2:0] meal;

  always_comb begin
    d0 = state.frame_bytes[3];
    d1 = state.frame_bytes[4];
    d2 = state.frame_bytes[5];
    d3 = state.frame_bytes[6];
    d4 = state.frame_bytes[7];
    d5 = state.frame_bytes[8];

    frame_ok = (state.byte_count < 5'(CountSat)) && state.header_matched &&
               (state.running_sum == check_byte) &&
               (state.frame_bytes[0] == record_return_id);
    is_summary = frame_ok && (state.byte_count == 5'(SummaryLen - 1)) &&
                 (state.frame_bytes[1] == 8'd0) && (state.frame_bytes[2] == 8'd0);
    is_record  = frame_ok && (state.byte_count == 5'(RecordLen - 1)) &&
                 ((state.frame_bytes[1] | state.frame_bytes[2]) != 8'd0) &&
                 !d3[7] && !d4[2];

    month = {1'b0, d1[7:6], 2'b00} + {3'b000, d0[7:6]} + 5'd1;
    day   = {1'b0, d0[4:0]} + 6'd1;
    meal  = d4[5:3];

    res_next = '0;
    if (is_summary) begin
      res_next.status          = STATUS_SUMMARY;
      res_next.record_total    = {state.frame_bytes[4], state.frame_bytes[3]};
      res_next.record_capacity = {state.frame_bytes[6], state.frame_bytes[5]};
      res_next.last_sent_index = {state.frame_bytes[8], state.frame_bytes[7]};
    end else if (is_record) begin
      res_next.status        = STATUS_RECORD;
      res_next.glucose_value = {d4[1:0], d5};
      // Fields overlap on purpose; overlapping bits are OR-merged.
      res_next.measured_key  = (27'(d3[6:0]) << 20) | (27'(month) << 16) |
                               (27'(day) << 11) | (27'(d1[4:0]) << 6) |
                               27'(d2[5:0]);
      case (meal)
        3'd0:    res_next.meal_mode = MEAL_BEFORE;
        3'd1:    res_next.meal_mode = MEAL_AFTER;
        default: res_next.meal_mode = MEAL_GENERAL;
      endcase
    end else begin
      res_next.status = STATUS_REJECTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res_next;
    end
  end

endmodule

// ----- sim/grfd_frame_checker.sv -----
`timescale 1ns / 100ps
// Frame decoder checker: follows register writes, decodes every accepted
// frame byte on its own and compares each output transaction in order.
// Depends on grfd_pkg.
module grfd_frame_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  grfd_pkg::frame_in_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  grfd_pkg::frame_out_t out_data,
  input  logic                 cfg_wr_en,
  input  logic [0:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   fail_count,
  output int                   outstanding
);
  import grfd_pkg::*;

  logic [7:0] hdr_reg;
  logic [7:0] rid_reg;
  logic [4:0] seen_count;
  logic [7:0] sum8;
  logic       header_ok;
  logic [7:0] kept [1:NumKept];
  frame_out_t decoded_results[$];
  int         errors = 0;

  // Advances the frame state by one byte; a marked byte yields a result.
  task automatic decode_byte(input frame_in_t item, output bit done,
                             output frame_out_t res);
    bit          ok;
    int unsigned len;
    logic [31:0] month, day, hour, minute, year, meal, key;
    done = 1'b0;
    res  = '0;
    if (!item.last_byte) begin
      if (seen_count == 0) header_ok = (item.byte_value == hdr_reg);
      if (seen_count >= 1 && seen_count <= NumKept) kept[seen_count] = item.byte_value;
      sum8 = sum8 + item.byte_value;
      if (seen_count < CountSat) seen_count = seen_count + 1'b1;
    end else begin
      len = seen_count + 1;
      ok  = (seen_count < CountSat) && header_ok && (sum8 == item.byte_value) &&
            (kept[1] == rid_reg);
      if (ok && len == SummaryLen && kept[2] == 8'd0 && kept[3] == 8'd0) begin
        res.status          = STATUS_SUMMARY;
        res.record_total    = {kept[5], kept[4]};
        res.record_capacity = {kept[7], kept[6]};
        res.last_sent_index = {kept[9], kept[8]};
      end else if (ok && len == RecordLen && (kept[2] | kept[3]) != 8'd0 &&
                   !kept[7][7] && !kept[8][2]) begin
        month  = ((kept[5] & 8'hC0) >> 4) + ((kept[4] & 8'hC0) >> 6) + 1;
        day    = (kept[4] & 8'h1F) + 1;
        hour   = kept[5] & 8'h1F;
        minute = kept[6] & 8'h3F;
        year   = kept[7] & 8'h7F;
        meal   = (kept[8] >> 3) & 8'h07;
        key    = (year << 20) | (month << 16) | (day << 11) | (hour << 6) | minute;
        res.status        = STATUS_RECORD;
        res.glucose_value = {kept[8][1:0], kept[9]};
        res.measured_key  = key[26:0];
        case (meal)
          0:       res.meal_mode = MEAL_BEFORE;
          1:       res.meal_mode = MEAL_AFTER;
          default: res.meal_mode = MEAL_GENERAL;
        endcase
      end
      done       = 1'b1;
      seen_count = '0;
      sum8       = '0;
      header_ok  = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    bit         done;
    frame_out_t res;
    frame_out_t want;
    if (rst) begin
      hdr_reg    = HeaderReset;
      rid_reg    = ReturnReset;
      seen_count = '0;
      sum8       = '0;
      header_ok  = 1'b0;
      for (int i = 1; i <= NumKept; i++) kept[i] = '0;
      decoded_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_HEADER_BYTE:      hdr_reg = cfg_data;
          REG_RECORD_RETURN_ID: rid_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        decode_byte(in_data, done, res);
        if (done) decoded_results.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (decoded_results.size() == 0) begin
          $display("%0t: unexpected result: expected none actual %h", $time, out_data);
          errors++;
        end else begin
          want = decoded_results.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("record_total", want.record_total, out_data.record_total);
          check_field("record_capacity", want.record_capacity,
                      out_data.record_capacity);
          check_field("last_sent_index", want.last_sent_index, out_data.last_sent_index);
          check_field("glucose_value", want.glucose_value, out_data.glucose_value);
          check_field("measured_key", want.measured_key, out_data.measured_key);
          check_field("meal_mode", want.meal_mode, out_data.meal_mode);
        end
      end
    end
    // published as registered values so the stimulus side reads them race-free
    fail_count  <= errors;
    outstanding <= decoded_results.size();
  end

endmodule

// ----- sim/glucose_record_frame_decoder_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the glucose record frame decoder: builds response
// frames, drives both handshakes and prints the verdict.
// Depends on grfd_pkg, grfd_frame_checker and the decoder RTL.
module glucose_record_frame_decoder_tb;
  import grfd_pkg::*;

  localparam int BytesPerPhase = 375;
  localparam int HoldCycles    = 400;   // long receiver hold-off
  localparam int IdleLimit     = 5000;  // cycles without any transaction

  // Ways a frame gets broken; BREAK_CHECKSUM is applied after sealing.
  typedef enum int {
    BREAK_HEADER, BREAK_RETURN_ID, BREAK_INDEX, BREAK_HI_FLAG, BREAK_CONTROL,
    BREAK_DROP_BYTE, BREAK_ADD_BYTE, BREAK_OVERLONG, BREAK_CHECKSUM
  } frame_fault_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  frame_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  frame_out_t out_data;
  logic       cfg_wr_en = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  int fail_count;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int bytes_sent = 0;

  // register values the frame builder aims at
  logic [7:0] hdr_now = HeaderReset;
  logic [7:0] rid_now = ReturnReset;
  logic [7:0] frame_buf[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  glucose_record_frame_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  grfd_frame_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // Receiver: random stalls, or a counted hold-off when one is requested.
  // hold_left is only set by the stimulus while it is zero, and only
  // counted down here while it is nonzero.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input transaction. Idle cycles go in before valid rises; once
  // raised, valid stays up with the same byte until accepted.
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, last};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      push_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // Header, return id, index and payload; checksum comes from seal_frame.
  task automatic build_body(input bit summary);
    int len;
    len = summary ? SummaryLen : RecordLen;
    frame_buf.delete();
    frame_buf.push_back(hdr_now);
    frame_buf.push_back(rid_now);
    for (int i = 2; i < len - 1; i++) frame_buf.push_back(8'($urandom_range(255)));
    if (summary) begin
      frame_buf[2] = 8'h00;
      frame_buf[3] = 8'h00;
    end else begin
      // nonzero index, Hi and control-solution flags clear
      if (frame_buf[2] == 8'h00 && frame_buf[3] == 8'h00) frame_buf[3] = 8'h01;
      frame_buf[7] = frame_buf[7] & 8'h7F;
      frame_buf[8] = frame_buf[8] & 8'hFB;
    end
  endtask

  task automatic seal_frame();
    logic [7:0] sum;
    sum = '0;
    foreach (frame_buf[i]) sum = sum + frame_buf[i];
    frame_buf.push_back(sum);
  endtask

  task automatic faulty_frame(input frame_fault_t fault, input bit summary);
    int n;
    build_body(summary);
    case (fault)
      BREAK_HEADER:    frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(255, 1));
      BREAK_RETURN_ID: frame_buf[1] = frame_buf[1] ^ 8'($urandom_range(255, 1));
      BREAK_INDEX: begin
        if (summary) begin
          frame_buf[2 + $urandom_range(1)] = 8'h01 << $urandom_range(7);
        end else begin
          frame_buf[2] = 8'h00;
          frame_buf[3] = 8'h00;
        end
      end
      BREAK_HI_FLAG:   frame_buf[7] = frame_buf[7] | 8'h80;
      BREAK_CONTROL:   frame_buf[8] = frame_buf[8] | 8'h04;
      BREAK_DROP_BYTE: frame_buf.delete($urandom_range(frame_buf.size() - 1, 1));
      BREAK_ADD_BYTE:  frame_buf.insert($urandom_range(frame_buf.size() - 1, 1),
                                        8'($urandom_range(255)));
      BREAK_OVERLONG: begin
        // 22 body bytes or more saturates the count
        n = $urandom_range(32, 21);
        while (frame_buf.size() < n) frame_buf.push_back(8'($urandom_range(255)));
      end
      default: ;
    endcase
    seal_frame();
    if (fault == BREAK_CHECKSUM)
      frame_buf[frame_buf.size() - 1] = frame_buf[frame_buf.size() - 1] ^
                                        8'($urandom_range(255, 1));
    send_frame();
  endtask

  // Random junk of 1 to 31 bytes, including a lone marked byte; sometimes it
  // carries a valid header, return id or checksum.
  task automatic noise_frame();
    int n;
    n = $urandom_range(30);
    frame_buf.delete();
    for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom_range(255)));
    if (n > 0 && $urandom_range(1)) frame_buf[0] = hdr_now;
    if (n > 1 && $urandom_range(1)) frame_buf[1] = rid_now;
    if ($urandom_range(1)) seal_frame();
    else frame_buf.push_back(8'($urandom_range(255)));
    send_frame();
  endtask

  // Waits until every expected result has come out and the output stage
  // is surely empty.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  // Only called with the block idle; write enable drops after the second write.
  task automatic set_registers(input logic [7:0] hdr, input logic [7:0] rid);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_HEADER_BYTE;
    cfg_data  <= hdr;
    @(posedge clk);
    cfg_index <= REG_RECORD_RETURN_ID;
    cfg_data  <= rid;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    hdr_now = hdr;
    rid_now = rid;
  endtask

  initial begin : stimulus
    int target;
    int pick;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset register values. The first frame is a full
    // summary so that every kept byte is written before any short frame.
    build_body(1'b1);
    for (int i = 4; i <= 9; i++) frame_buf[i] = 8'hFF;
    seal_frame();
    send_frame();
    // lone marked byte, checksum of an empty sum
    frame_buf.delete();
    frame_buf.push_back(8'h00);
    send_frame();
    build_body(1'b1);
    for (int i = 4; i <= 9; i++) frame_buf[i] = 8'h00;
    seal_frame();
    send_frame();
    // record with every date bit set and the general meal code
    build_body(1'b0);
    frame_buf[2] = 8'hFF;
    frame_buf[3] = 8'hFF;
    for (int i = 4; i <= 9; i++) frame_buf[i] = 8'hFF;
    frame_buf[7] = 8'h7F;
    frame_buf[8] = 8'hFB;
    seal_frame();
    send_frame();
    // record with smallest index, zero date and the before/after meal codes
    for (int m = 0; m < 2; m++) begin
      build_body(1'b0);
      frame_buf[2] = 8'h01;
      frame_buf[3] = 8'h00;
      for (int i = 4; i <= 9; i++) frame_buf[i] = 8'h00;
      frame_buf[8] = 8'(m << 3);
      seal_frame();
      send_frame();
    end
    // every kind of broken record, plus a summary with a nonzero index
    for (int f = BREAK_HEADER; f <= BREAK_CHECKSUM; f++)
      faulty_frame(frame_fault_t'(f), 1'b0);
    faulty_frame(BREAK_INDEX, 1'b1);

    // Random part: four idling phases, each with its own register setting.
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          set_registers(8'h00, 8'hFF);
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          set_registers(8'hFF, 8'h00);
          send_idle_pct = 72;
          stall_pct     = 0;
        end
        2: begin
          set_registers(8'($urandom_range(255)), 8'($urandom_range(255)));
          send_idle_pct = 0;
          stall_pct     = 72;
        end
        default: begin
          set_registers(HeaderReset, ReturnReset);
          send_idle_pct = 28;
          stall_pct     = 28;
        end
      endcase
      // receiver goes quiet while frames keep coming, so a marked byte
      // backs up behind the held result
      if (ph == 0 || ph == 3) hold_left = HoldCycles;
      target = bytes_sent + BytesPerPhase;
      while (bytes_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          build_body(1'($urandom_range(1)));
          seal_frame();
          send_frame();
        end else if (pick < 92) begin
          faulty_frame(frame_fault_t'($urandom_range(BREAK_CHECKSUM)),
                       1'($urandom_range(1)));
        end else begin
          noise_frame();
        end
      end
    end

    settle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
